>>> hw/rtl/newton_interpolation_engine_defines.svh
// ---------------------------------------------------------------------------
// Newton interpolation engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NEWTON_INTERPOLATION_ENGINE_DEFINES_SVH
`define NEWTON_INTERPOLATION_ENGINE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define NIE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nie: invariant violated");

// Condition in one cycle implies a consequence in the next.
`define NIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nie: sequencing violated");

`endif

>>> hw/rtl/nie_pkg.sv
// ---------------------------------------------------------------------------
// nie_pkg
// Constants, codes and controller/datapath bundles of the interpolation engine.
// ---------------------------------------------------------------------------
package nie_pkg;

  localparam int MAX_NODES      = 16;
  localparam int COEF_FRAC_BITS = 40;
  localparam int SLOT_LIMIT     = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int ADDR_W         = $clog2(MAX_NODES);
  localparam int CNT_W          = ADDR_W + 1;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_SAT       = 2'd2,
    ST_REPEAT    = 2'd3
  } status_t;

  typedef struct packed {
    logic              take;
    logic              load_wr;
    logic              build_clr;
    logic              div_start;
    logic              coef_wr;
    logic              p_init;
    logic              mul_set;
    logic              mul_lo;
    logic              mul_hi;
    logic              mul_cmb;
    logic              acc_add;
    logic              emit;
    logic              emit_nr;
    logic [ADDR_W-1:0] ca;
    logic [ADDR_W-1:0] cb;
    logic [ADDR_W-1:0] na;
    logic [ADDR_W-1:0] nb;
  } nie_cmd_t;

  typedef struct packed {
    func_t      func;
    logic [3:0] idx;
    logic       div_done;
    logic       out_busy;
  } nie_sts_t;

endpackage

>>> hw/rtl/nie_ifs.sv
// ---------------------------------------------------------------------------
// Interpolation engine channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface nie_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         node_index;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source(output valid, func, node_index, x_value, y_value, input ready);
  modport sink(input valid, func, node_index, x_value, y_value, output ready);
endinterface

interface nie_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] poly_value;
  logic [1:0]         status;

  modport source(output valid, poly_value, status, input ready);
  modport sink(input valid, poly_value, status, output ready);
endinterface

>>> hw/rtl/newton_interpolation_engine.sv
// ---------------------------------------------------------------------------
// newton_interpolation_engine
// Newton divided-difference interpolation: node loads, build, evaluation.
// ---------------------------------------------------------------------------
// Items are handled one at a time. Loading the node in the last slot in
// use builds the coefficients in place with n(n-1)/2 divisions; each
// division is a restoring radix-2 divider giving one quotient bit a cycle
// over a 94-bit dividend, between read, setup and write-back states.
// An evaluation runs the multiply-add loop n-1 times: the 64x33 product
// is formed in two 32-bit halves, then saturated, then added.
// A result waits in an output register, so the next item is taken while it
// is still held.
module newton_interpolation_engine (
  input  logic       clk,
  input  logic       rst_n,
  nie_in_if.sink     in_chan,
  nie_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  nie_pkg::nie_cmd_t cmd;
  nie_pkg::nie_sts_t sts;

  nie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  nie_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_chan.func),
    .in_node_index  (in_chan.node_index),
    .in_x_value     (in_chan.x_value),
    .in_y_value     (in_chan.y_value),
    .out_ready      (out_chan.ready),
    .sts            (sts),
    .out_valid      (out_chan.valid),
    .out_poly_value (out_chan.poly_value),
    .out_status     (out_chan.status)
  );

endmodule

>>> hw/rtl/nie_dp.sv
// ---------------------------------------------------------------------------
// nie_dp
// Node and coefficient stores, radix-2 divider, split multiplier, output reg.
// ---------------------------------------------------------------------------
module nie_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  nie_pkg::nie_cmd_t  cmd,
  input  logic               in_func,
  input  logic [3:0]         in_node_index,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  input  logic               out_ready,
  output nie_pkg::nie_sts_t  sts,
  output logic               out_valid,
  output logic signed [63:0] out_poly_value,
  output logic [1:0]         out_status
);

  localparam int DIV_STEPS = 64 + 30;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int SH_L      = (nie_pkg::COEF_FRAC_BITS >= 30) ? nie_pkg::COEF_FRAC_BITS - 30 : 0;
  localparam int SH_R      = (nie_pkg::COEF_FRAC_BITS < 30) ? 30 - nie_pkg::COEF_FRAC_BITS : 0;

  function automatic logic signed [63:0] y_to_coef(input logic signed [31:0] y);
    logic signed [63:0] yw;
    yw = 64'(y);
    if (nie_pkg::COEF_FRAC_BITS >= 30) begin
      return yw <<< SH_L;
    end
    return yw >>> SH_R;
  endfunction

  // {overflow, value}
  function automatic logic [64:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [63:0] v;
    logic        o;
    o = 1'b0;
    if (neg) begin
      if (mag[63]) begin
        o = |mag[62:0];
        v = {1'b1, 63'd0};
      end else begin
        v = 64'd0 - mag;
      end
    end else begin
      if (mag[63]) begin
        o = 1'b1;
        v = {1'b0, {63{1'b1}}};
      end else begin
        v = mag;
      end
    end
    return {o, v};
  endfunction

  // item register
  nie_pkg::func_t     item_func_r;
  logic [3:0]         item_idx_r;
  logic signed [31:0] item_x_r;
  logic signed [31:0] item_y_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_func_r <= nie_pkg::func_t'(in_func);
      item_idx_r  <= in_node_index;
      item_x_r    <= in_x_value;
      item_y_r    <= in_y_value;
    end
  end

  // stores
  logic signed [31:0] node_mem [nie_pkg::MAX_NODES];
  logic signed [63:0] coef_mem [nie_pkg::MAX_NODES];
  logic signed [31:0] na_q_r, nb_q_r;
  logic signed [63:0] ca_q_r, cb_q_r;
  logic [64:0]        div_res;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      node_mem[nie_pkg::ADDR_W'(item_idx_r)] <= item_x_r;
      coef_mem[nie_pkg::ADDR_W'(item_idx_r)] <= y_to_coef(item_y_r);
    end else if (cmd.coef_wr) begin
      coef_mem[cmd.ca] <= div_res[63:0];
    end
    ca_q_r <= coef_mem[cmd.ca];
    cb_q_r <= coef_mem[cmd.cb];
    na_q_r <= node_mem[cmd.na];
    nb_q_r <= node_mem[cmd.nb];
  end

  // divider: (|num| << 30) / |den|, one quotient bit per cycle
  logic [DIV_STEPS-1:0] dvd_r;
  logic [33:0]          rem_r;
  logic [63:0]          quo_r;
  logic                 big_r, zero_r, neg_r;
  logic [32:0]          dm_r;
  logic [DCNT_W-1:0]    cnt_r;

  logic signed [32:0] bdx;
  logic [63:0]        bnm;
  logic [32:0]        bdm;
  logic               bnn, bdn;
  logic [33:0]        rem2;
  logic               ge;

  always_comb begin
    bnn = ca_q_r < cb_q_r;
    bnm = bnn ? 64'(cb_q_r - ca_q_r) : 64'(ca_q_r - cb_q_r);
    bdx = 33'(na_q_r) - 33'(nb_q_r);
    bdn = bdx[32];
    bdm = bdn ? 33'(-bdx) : 33'(bdx);
    rem2 = {rem_r[32:0], dvd_r[DIV_STEPS-1]};
    ge   = rem2 >= 34'(dm_r);
    div_res = zero_r ? 65'd0 : sat_mag(neg_r, big_r ? {64{1'b1}} : quo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= DCNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r  <= {bnm, 30'd0};
      rem_r  <= '0;
      quo_r  <= '0;
      big_r  <= 1'b0;
      dm_r   <= bdm;
      zero_r <= bdm == '0;
      neg_r  <= bnn ^ bdn;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DIV_STEPS-2:0], 1'b0};
      big_r <= big_r | quo_r[63];
      quo_r <= {quo_r[62:0], ge};
      rem_r <= ge ? rem2 - 34'(dm_r) : rem2;
    end
  end

  // evaluation: p = p * (x - x[j-1]) >> 30 + c[j-1], product in two halves
  logic signed [63:0] p_r;
  logic [63:0]        pm_r;
  logic               pn_r, dn_r;
  logic [32:0]        dm_m_r;
  logic [64:0]        lo_r, hi_r;
  logic               ov_r, bsat_r, fault_r;

  logic signed [32:0] edx;
  logic [67:0]        msum;
  logic [64:0]        mres;
  logic signed [64:0] asum;

  always_comb begin
    edx  = 33'(item_x_r) - 33'(nb_q_r);
    msum = {1'b0, hi_r, 2'b00} + 68'(lo_r >> 30);
    mres = sat_mag(pn_r ^ dn_r, (|msum[67:64]) ? {64{1'b1}} : msum[63:0]);
    asum = 65'(p_r) + 65'(cb_q_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_set) begin
      pn_r   <= p_r[63];
      pm_r   <= p_r[63] ? 64'd0 - 64'(p_r) : 64'(p_r);
      dn_r   <= edx[32];
      dm_m_r <= edx[32] ? 33'(-edx) : 33'(edx);
    end
    if (cmd.mul_lo) begin
      lo_r <= 65'(pm_r[31:0]) * 65'(dm_m_r);
    end
    if (cmd.mul_hi) begin
      hi_r <= 65'(pm_r[63:32]) * 65'(dm_m_r);
    end
    if (cmd.p_init) begin
      p_r <= ca_q_r;
    end else if (cmd.mul_cmb) begin
      p_r <= mres[63:0];
    end else if (cmd.acc_add) begin
      if (asum[64] != asum[63]) begin
        p_r <= asum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        p_r <= asum[63:0];
      end
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      bsat_r  <= 1'b0;
      fault_r <= 1'b0;
    end else begin
      if (cmd.p_init) begin
        ov_r <= 1'b0;
      end else if (cmd.mul_cmb) begin
        ov_r <= ov_r | mres[64];
      end else if (cmd.acc_add) begin
        ov_r <= ov_r | (asum[64] != asum[63]);
      end
      if (cmd.build_clr) begin
        bsat_r  <= 1'b0;
        fault_r <= 1'b0;
      end else if (cmd.coef_wr) begin
        fault_r <= fault_r | zero_r;
        bsat_r  <= bsat_r | div_res[64];
      end
    end
  end

  // output register
  logic               out_valid_r;
  logic signed [63:0] out_poly_r;
  nie_pkg::status_t   out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_nr) begin
        out_poly_r   <= '0;
        out_status_r <= nie_pkg::ST_NOT_READY;
      end else begin
        out_poly_r <= p_r;
        if (fault_r) begin
          out_status_r <= nie_pkg::ST_REPEAT;
        end else if (ov_r || bsat_r) begin
          out_status_r <= nie_pkg::ST_SAT;
        end else begin
          out_status_r <= nie_pkg::ST_OK;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_poly_value = out_poly_r;
  assign out_status     = out_status_r;

  assign sts.func     = item_func_r;
  assign sts.idx      = item_idx_r;
  assign sts.div_done = cnt_r == '0;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

>>> hw/rtl/nie_ctrl.sv
// ---------------------------------------------------------------------------
// nie_ctrl
// Sequencer for node loads, coefficient build and Newton-form evaluation.
// ---------------------------------------------------------------------------
`include "newton_interpolation_engine_defines.svh"

module nie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  nie_pkg::nie_sts_t sts,
  output nie_pkg::nie_cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DECODE = 15'b000000000000010,
    S_B_RD   = 15'b000000000000100,
    S_B_LD   = 15'b000000000001000,
    S_B_DIV  = 15'b000000000010000,
    S_B_WR   = 15'b000000000100000,
    S_E_RD0  = 15'b000000001000000,
    S_E_INIT = 15'b000000010000000,
    S_E_RD   = 15'b000000100000000,
    S_E_SET  = 15'b000001000000000,
    S_E_LO   = 15'b000010000000000,
    S_E_HI   = 15'b000100000000000,
    S_E_CMB  = 15'b001000000000000,
    S_E_ADD  = 15'b010000000000000,
    S_EMIT   = 15'b100000000000000
  } state_t;

  localparam int CW = nie_pkg::CNT_W;
  localparam int AW = nie_pkg::ADDR_W;

  state_t        state_r, state_nxt;
  logic [4:0]    node_count_r;
  logic          ready_r, ready_nxt;
  logic          nr_r, nr_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;

  logic [4:0]    n5;
  logic [CW-1:0] n_c, jm1, jmi;
  logic          idx_ok, idx_last;

  always_comb begin
    if (node_count_r < 5'd2) begin
      n5 = 5'd2;
    end else if (node_count_r > 5'(nie_pkg::SLOT_LIMIT)) begin
      n5 = 5'(nie_pkg::SLOT_LIMIT);
    end else begin
      n5 = node_count_r;
    end
    n_c      = CW'(n5);
    jm1      = j_r - 1'b1;
    jmi      = j_r - i_r;
    idx_ok   = {1'b0, sts.idx} < n5;
    idx_last = {1'b0, sts.idx} == n5 - 5'd1;
  end

  always_comb begin
    cmd       = '0;
    cmd.ca    = j_r[AW-1:0];
    cmd.cb    = jm1[AW-1:0];
    cmd.na    = j_r[AW-1:0];
    cmd.nb    = jmi[AW-1:0];
    in_ready  = 1'b0;
    state_nxt = state_r;
    ready_nxt = ready_r;
    nr_nxt    = nr_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (sts.func == nie_pkg::FUNC_LOAD) begin
          if (idx_ok) begin
            cmd.load_wr = 1'b1;
            ready_nxt   = 1'b0;
            if (idx_last) begin
              cmd.build_clr = 1'b1;
              i_nxt         = CW'(1);
              j_nxt         = n_c - 1'b1;
              state_nxt     = S_B_RD;
            end
          end
        end else begin
          nr_nxt = !ready_r;
          i_nxt  = CW'(1);
          j_nxt  = n_c - 1'b1;
          state_nxt = ready_r ? S_E_RD0 : S_EMIT;
        end
      end
      S_B_RD: state_nxt = S_B_LD;
      S_B_LD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_B_DIV;
      end
      S_B_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_B_WR;
        end
      end
      S_B_WR: begin
        cmd.coef_wr = 1'b1;
        state_nxt   = S_B_RD;
        if (j_r == i_r) begin
          if (i_r + 1'b1 == n_c) begin
            ready_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = n_c - 1'b1;
          end
        end else begin
          j_nxt = jm1;
        end
      end
      S_E_RD0: state_nxt = S_E_INIT;
      S_E_INIT: begin
        cmd.p_init = 1'b1;
        state_nxt  = S_E_SET;
      end
      S_E_RD: state_nxt = S_E_SET;
      S_E_SET: begin
        cmd.mul_set = 1'b1;
        state_nxt   = S_E_LO;
      end
      S_E_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_E_HI;
      end
      S_E_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_E_CMB;
      end
      S_E_CMB: begin
        cmd.mul_cmb = 1'b1;
        state_nxt   = S_E_ADD;
      end
      S_E_ADD: begin
        cmd.acc_add = 1'b1;
        if (j_r == CW'(1)) begin
          state_nxt = S_EMIT;
        end else begin
          j_nxt     = jm1;
          state_nxt = S_E_RD;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit    = 1'b1;
          cmd.emit_nr = nr_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= 5'd15;
      ready_r      <= 1'b0;
      nr_r         <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      state_r <= state_nxt;
      nr_r    <= nr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
        ready_r      <= 1'b0;
      end else begin
        ready_r <= ready_nxt;
      end
    end
  end

  logic in_build;
  assign in_build = (state_r == S_B_RD) || (state_r == S_B_LD) ||
                    (state_r == S_B_DIV) || (state_r == S_B_WR);

  `NIE_ASSERT(a_emit_free, !(cmd.emit && sts.out_busy))
  `NIE_ASSERT_NXT(a_div_busy, state_r == S_B_LD, !sts.div_done)
  `NIE_ASSERT(a_ready_from_build, !$rose(ready_r) || $past(state_r == S_B_WR))
  `NIE_ASSERT(a_build_bounds, !in_build || (j_r >= i_r && j_r < n_c && i_r != '0))

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Newton interpolation engine testbench
// A directed sequence, then random node sets with evaluations under several
// node counts. Results are checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    nie_pkg::func_t     func;
    logic [3:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } node_item_t;

  typedef struct {
    logic signed [63:0] value;
    nie_pkg::status_t   status;
  } poly_result_t;

  class newton_predictor;
    logic signed [31:0] node_x[16];
    logic signed [63:0] coef[16];
    bit                 coef_valid;
    bit                 repeat_fault;
    bit                 build_sat;
    logic [4:0]         count_reg;
    poly_result_t       expected_results[$];
    int                 mismatches;

    function new();
      coef_valid   = 0;
      repeat_fault = 0;
      build_sat    = 0;
      count_reg    = 5'd15;
      mismatches   = 0;
      foreach (node_x[i]) begin
        node_x[i] = '0;
        coef[i]   = '0;
      end
    endfunction

    function int active_nodes();
      int n;
      n = int'(count_reg);
      if (n < 2) n = 2;
      if (n > nie_pkg::SLOT_LIMIT) n = nie_pkg::SLOT_LIMIT;
      return n;
    endfunction

    function void set_count(logic [4:0] v);
      count_reg  = v;
      coef_valid = 0;
    endfunction

    function logic signed [63:0] clamp(bit neg, logic [127:0] mag, inout bit ov);
      logic [127:0] lim;
      lim = 128'd1 << 63;
      if (neg) begin
        if (mag >= lim) begin
          if (mag > lim) ov = 1;
          return 64'sh8000_0000_0000_0000;
        end
        return -$signed(mag[63:0]);
      end
      if (mag >= lim) begin
        ov = 1;
        return 64'sh7fff_ffff_ffff_ffff;
      end
      return $signed(mag[63:0]);
    endfunction

    function logic signed [63:0] mul_q30(logic signed [63:0] p, logic signed [127:0] d,
                                         inout bit ov);
      logic signed [127:0] pw;
      logic [127:0]        pm, dm;
      pw = p;
      pm = (pw < 0) ? -pw : pw;
      dm = (d < 0) ? -d : d;
      return clamp((pw < 0) != (d < 0), (pm * dm) >> 30, ov);
    endfunction

    function void build_coefficients(int n);
      logic signed [127:0] num, den;
      logic [127:0]        nm, dm;
      repeat_fault = 0;
      build_sat    = 0;
      for (int i = 1; i < n; i++) begin
        for (int j = n - 1; j >= i; j--) begin
          num = coef[j];
          num = num - coef[j-1];
          den = node_x[j];
          den = den - node_x[j-i];
          if (den == 0) begin
            repeat_fault = 1;
            coef[j] = '0;
          end else begin
            nm = (num < 0) ? -num : num;
            dm = (den < 0) ? -den : den;
            coef[j] = clamp((num < 0) != (den < 0), (nm << 30) / dm, build_sat);
          end
        end
      end
      coef_valid = 1;
    endfunction

    function void note_item(node_item_t it);
      int                  n;
      poly_result_t        r;
      logic signed [63:0]  p;
      logic signed [127:0] d, s;
      bit                  ov;
      n  = active_nodes();
      ov = 0;
      if (it.func == nie_pkg::FUNC_LOAD) begin
        if (it.idx >= n) return;
        node_x[it.idx] = it.x;
        coef[it.idx]   = 64'(it.y) <<< (nie_pkg::COEF_FRAC_BITS - 30);
        coef_valid     = 0;
        if (it.idx == n - 1) build_coefficients(n);
        return;
      end
      if (!coef_valid) begin
        r.value  = '0;
        r.status = nie_pkg::ST_NOT_READY;
      end else begin
        p = coef[n-1];
        for (int i = n - 1; i > 0; i--) begin
          d = it.x;
          d = d - node_x[i-1];
          p = mul_q30(p, d, ov);
          s = p;
          s = s + coef[i-1];
          p = clamp(s < 0, (s < 0) ? -s : s, ov);
        end
        r.value = p;
        if (repeat_fault) r.status = nie_pkg::ST_REPEAT;
        else if (ov || build_sat) r.status = nie_pkg::ST_SAT;
        else r.status = nie_pkg::ST_OK;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic signed [63:0] value, logic [1:0] status);
      poly_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h status %0d", value, status);
        return;
      end
      e = expected_results.pop_front();
      if (value !== e.value || status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                   e.value, e.status, value, status);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  bit         idle_on;
  bit         written[16];
  int         n_nodes;

  nie_in_if  in_chan();
  nie_out_if out_chan();
  newton_predictor pred;

  newton_interpolation_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("newton_interpolation_engine regression: fail");
    $finish;
  end

  // result side: stall at random, check every transfer
  always @(negedge clk) begin
    out_chan.ready = !(idle_on && $urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      pred.check_result(out_chan.poly_value, out_chan.status);
  end

  task automatic send(node_item_t it);
    if (idle_on && $urandom_range(99) < 15) begin
      @(negedge clk);
      in_chan.valid = 0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid      = 1;
    in_chan.func       = it.func;
    in_chan.node_index = it.idx;
    in_chan.x_value    = it.x;
    in_chan.y_value    = it.y;
    do @(posedge clk); while (!in_chan.ready);
    pred.note_item(it);
    if (it.func == nie_pkg::FUNC_LOAD && it.idx < n_nodes) written[it.idx] = 1;
  endtask

  task automatic send_fields(nie_pkg::func_t f, int idx, logic signed [31:0] x,
                             logic signed [31:0] y);
    node_item_t it;
    it.func = f;
    it.idx  = 4'(idx);
    it.x    = x;
    it.y    = y;
    send(it);
  endtask

  // an evaluation is taken only after any build finishes, so its result
  // arriving means the block is idle
  task automatic drain();
    send_fields(nie_pkg::FUNC_EVAL, 0, 0, 0);
    @(negedge clk);
    in_chan.valid = 0;
    while (pred.expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_count(logic [4:0] v);
    drain();
    @(negedge clk);
    cfg_we    = 1;
    cfg_wdata = v;
    @(posedge clk);
    pred.set_count(v);
    @(negedge clk);
    cfg_we  = 0;
    n_nodes = pred.active_nodes();
  endtask

  function automatic logic signed [31:0] rand_x();
    if ($urandom_range(9) == 0) return $signed($urandom_range(3) << 29);
    return $signed($urandom);
  endfunction

  function automatic logic signed [31:0] rand_y();
    if ($urandom_range(3) == 0) return $signed($urandom_range(255)) - 128;
    return $signed($urandom);
  endfunction

  task automatic run_phase(int budget);
    int         order[16];
    int         k, tmp, evals;
    bit         all_low;
    node_item_t it;
    while (budget > 0) begin
      if ($urandom_range(4) != 0) begin
        // full node set in random order, last slot last, then evaluations
        for (int i = 0; i < n_nodes - 1; i++) order[i] = i;
        for (int i = n_nodes - 2; i > 0; i--) begin
          k = $urandom_range(i);
          tmp = order[i]; order[i] = order[k]; order[k] = tmp;
        end
        order[n_nodes-1] = n_nodes - 1;
        for (int i = 0; i < n_nodes; i++)
          send_fields(nie_pkg::FUNC_LOAD, order[i], rand_x(), rand_y());
        budget -= n_nodes;
        evals = 1 + $urandom_range(3);
        for (int i = 0; i < evals; i++) begin
          if ($urandom_range(3) == 0)
            send_fields(nie_pkg::FUNC_EVAL, $urandom_range(15),
                        pred.node_x[$urandom_range(n_nodes-1)], $signed($urandom));
          else
            send_fields(nie_pkg::FUNC_EVAL, $urandom_range(15), $signed($urandom),
                        $signed($urandom));
        end
        budget -= evals;
      end else begin
        it.func = nie_pkg::func_t'($urandom_range(1));
        it.idx  = 4'($urandom_range(15));
        it.x    = rand_x();
        it.y    = rand_y();
        all_low = 1;
        for (int i = 0; i < n_nodes - 1; i++) all_low &= written[i];
        // a build must never read a slot that was never loaded
        if (it.func == nie_pkg::FUNC_LOAD && it.idx == n_nodes - 1 && !all_low) it.idx = 0;
        send(it);
        budget--;
      end
    end
  endtask

  initial begin
    int counts[12] = '{3, 2, 4, 0, 5, 31, 6, 1, 8, 16, 15, 3};
    int budgets[12] = '{0, 200, 200, 150, 180, 40, 160, 100, 130, 40, 40, 180};
    pred      = new();
    rst_n     = 0;
    cfg_we    = 0;
    cfg_wdata = '0;
    idle_on   = 1;
    n_nodes   = 15;
    foreach (written[i]) written[i] = 0;
    in_chan.valid      = 0;
    in_chan.func       = nie_pkg::FUNC_LOAD;
    in_chan.node_index = '0;
    in_chan.x_value    = '0;
    in_chan.y_value    = '0;
    out_chan.ready     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    @(negedge clk);
    cfg_we    = 1;
    cfg_wdata = 5'd3;
    @(posedge clk);
    pred.set_count(5'd3);
    @(negedge clk);
    cfg_we  = 0;
    n_nodes = 3;

    // directed: not ready, ignored slots, extremes, repeated nodes, saturation
    send_fields(nie_pkg::FUNC_EVAL, 0, 0, 0);
    send_fields(nie_pkg::FUNC_LOAD, 5, 32'sd7, 32'sd9);
    send_fields(nie_pkg::FUNC_LOAD, 15, -32'sd7, -32'sd9);
    send_fields(nie_pkg::FUNC_LOAD, 0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_fields(nie_pkg::FUNC_LOAD, 1, 32'sd0, 32'sh8000_0000);
    send_fields(nie_pkg::FUNC_LOAD, 2, 32'sh7fff_ffff, 32'sd0);
    send_fields(nie_pkg::FUNC_EVAL, 0, 32'sh7fff_ffff, 0);
    send_fields(nie_pkg::FUNC_EVAL, 15, 32'sh8000_0000, 32'sh7fff_ffff);
    send_fields(nie_pkg::FUNC_EVAL, 0, 32'sd0, 0);
    send_fields(nie_pkg::FUNC_EVAL, 0, 32'sh2000_0000, 0);
    send_fields(nie_pkg::FUNC_LOAD, 1, 32'sh8000_0000, 32'sd1);
    send_fields(nie_pkg::FUNC_LOAD, 2, 32'sd5, -32'sd1);
    send_fields(nie_pkg::FUNC_EVAL, 0, 32'sd3, 0);
    send_fields(nie_pkg::FUNC_LOAD, 0, 32'sd0, 32'sh7fff_ffff);
    send_fields(nie_pkg::FUNC_LOAD, 1, 32'sd1, 32'sh8000_0000);
    send_fields(nie_pkg::FUNC_LOAD, 2, 32'sd2, 32'sh7fff_ffff);
    send_fields(nie_pkg::FUNC_EVAL, 0, -32'sd1, 0);
    send_fields(nie_pkg::FUNC_EVAL, 0, 32'sd0, 0);
    send_fields(nie_pkg::FUNC_LOAD, 0, 32'sd100, 32'sd1000);
    send_fields(nie_pkg::FUNC_LOAD, 1, -32'sd200, -32'sd5);
    send_fields(nie_pkg::FUNC_LOAD, 2, 32'sh4000_0000, 32'sh4000_0000);
    send_fields(nie_pkg::FUNC_EVAL, 0, 32'sd7, 0);

    for (int ph = 1; ph < 12; ph++) begin
      write_count(5'(counts[ph]));
      idle_on = (ph != 4);  // one long stretch with no stalls on either side
      run_phase(budgets[ph]);
    end
    idle_on = 1;
    drain();
    repeat (50) @(posedge clk);

    if (pred.mismatches == 0 && pred.expected_results.size() == 0) begin
      $display("newton_interpolation_engine regression: pass");
    end else begin
      $display("newton_interpolation_engine regression: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nie_pkg.sv
hw/rtl/nie_ifs.sv
hw/rtl/nie_dp.sv
hw/rtl/nie_ctrl.sv
hw/rtl/newton_interpolation_engine.sv
bench/tb.sv
